// ===== src/ole_pkg.sv =====
`timescale 1ns / 1ps
// ole_pkg: shared types and constants for the ordered list engine
// no dependencies; used by the interfaces, controller, datapath and top level

package ole_pkg;

   localparam int OPCODE_W    = 3;
   localparam int POS_W       = 4;
   localparam int AGE_W       = 8;
   localparam int NAME_W      = 64;
   localparam int STATUS_W    = 2;
   localparam int TOTAL_W     = 5;
   localparam int REC_W       = AGE_W + NAME_W;
   localparam int MAX_RESULTS = 16;
   localparam int NMATCH_W    = $clog2(MAX_RESULTS + 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_TAIL   = 3'd0,
      OP_HEAD   = 3'd1,
      OP_INSERT = 3'd2,
      OP_REMOVE = 3'd3,
      OP_READ   = 3'd4,
      OP_SEARCH = 3'd5,
      OP_CLEAR  = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_BADPOS   = 2'd2,
      STAT_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_CHK,
      S_INS_WR,
      S_RM_CHK,
      S_RM_WR,
      S_RD_ISSUE,
      S_RD_OUT,
      S_SR_CHK,
      S_SR_CMP,
      S_SR_DONE,
      S_RES_OK,
      S_RES_FULL,
      S_RES_BAD
   } state_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_LOAD_COUNT,
      IDX_LOAD_POS,
      IDX_CLEAR,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_IDX_M1,
      RD_IDX_P1
   } rd_sel_type;

   typedef enum logic {
      WR_NEW,
      WR_RD
   } wr_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLEAR
   } cnt_op_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_STATUS,
      EMIT_READ,
      EMIT_PEND
   } emit_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [POS_W-1:0]    position;
      logic [AGE_W-1:0]    age;
      logic [NAME_W-1:0]   name_tag;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [AGE_W-1:0]    out_age;
      logic [NAME_W-1:0]   out_name;
      logic [POS_W-1:0]    out_position;
      logic [TOTAL_W-1:0]  entry_total;
      logic                last;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      idx_op_type idx_op;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      cnt_op_type cnt_op;
      logic       srch_init;
      logic       srch_take;
      emit_type   emit;
      status_type status;
      logic       last;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   full;
      logic   ins_bad;
      logic   pos_bad;
      logic   ins_here;
      logic   rm_end;
      logic   scan_end;
      logic   match;
      logic   pend_valid;
      logic   out_free;
   } dp_stat_type;

endpackage

// ===== src/ole_if.sv =====
`timescale 1ns / 1ps
// request and response channel interfaces of the ordered list engine
// depends on ole_pkg for the payload types

interface ole_req_if import ole_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ole_rsp_if import ole_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/ole_ram.sv =====
`timescale 1ns / 1ps
// ole_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module ole_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ole_ctrl.sv =====
`timescale 1ns / 1ps
// ole_ctrl: sequencing state machine of the ordered list engine
// depends on ole_pkg; drives the datapath through dp_cmd_type only

module ole_ctrl import ole_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.op) inside
               OP_TAIL, OP_HEAD, OP_INSERT: begin
                  // fullness wins over a bad position
                  if (stat.full) begin
                     state_in = S_RES_FULL;
                  end else if (stat.ins_bad) begin
                     state_in = S_RES_BAD;
                  end else begin
                     cmd.idx_op = IDX_LOAD_COUNT;
                     state_in   = S_INS_CHK;
                  end
               end
               OP_REMOVE: begin
                  if (stat.pos_bad) begin
                     state_in = S_RES_BAD;
                  end else begin
                     cmd.idx_op = IDX_LOAD_POS;
                     state_in   = S_RM_CHK;
                  end
               end
               OP_READ: begin
                  if (stat.pos_bad) begin
                     state_in = S_RES_BAD;
                  end else begin
                     cmd.idx_op = IDX_LOAD_POS;
                     state_in   = S_RD_ISSUE;
                  end
               end
               OP_SEARCH: begin
                  cmd.idx_op    = IDX_CLEAR;
                  cmd.srch_init = 1'b1;
                  state_in      = S_SR_CHK;
               end
               OP_CLEAR: begin
                  cmd.cnt_op = CNT_CLEAR;
                  state_in   = S_RES_OK;
               end
               default: begin
                  state_in = S_RES_OK;
               end
            endcase
         end
         S_INS_CHK: begin
            if (stat.ins_here) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_NEW;
               cmd.cnt_op = CNT_INC;
               state_in   = S_RES_OK;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX_M1;
               state_in   = S_INS_WR;
            end
         end
         S_INS_WR: begin
            // move entry idx-1 up into idx
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_RD;
            cmd.idx_op = IDX_DEC;
            state_in   = S_INS_CHK;
         end
         S_RM_CHK: begin
            if (stat.rm_end) begin
               cmd.cnt_op = CNT_DEC;
               state_in   = S_RES_OK;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX_P1;
               state_in   = S_RM_WR;
            end
         end
         S_RM_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_RD;
            cmd.idx_op = IDX_INC;
            state_in   = S_RM_CHK;
         end
         S_RD_ISSUE: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = S_RD_OUT;
         end
         S_RD_OUT: begin
            if (stat.out_free) begin
               cmd.emit = EMIT_READ;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SR_CHK: begin
            if (stat.scan_end) begin
               state_in = S_SR_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX;
               state_in   = S_SR_CMP;
            end
         end
         S_SR_CMP: begin
            // a match is held back one step so the final one can carry last
            if (!stat.match) begin
               cmd.idx_op = IDX_INC;
               state_in   = S_SR_CHK;
            end else if (!stat.pend_valid) begin
               cmd.srch_take = 1'b1;
               cmd.idx_op    = IDX_INC;
               state_in      = S_SR_CHK;
            end else if (stat.out_free) begin
               cmd.emit      = EMIT_PEND;
               cmd.srch_take = 1'b1;
               cmd.idx_op    = IDX_INC;
               state_in      = S_SR_CHK;
            end
         end
         S_SR_DONE: begin
            if (stat.out_free) begin
               cmd.last = 1'b1;
               state_in = S_IDLE;
               if (stat.pend_valid) begin
                  cmd.emit = EMIT_PEND;
               end else begin
                  cmd.emit   = EMIT_STATUS;
                  cmd.status = STAT_NOTFOUND;
               end
            end
         end
         S_RES_OK: begin
            if (stat.out_free) begin
               cmd.emit   = EMIT_STATUS;
               cmd.status = STAT_OK;
               cmd.last   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_RES_FULL: begin
            if (stat.out_free) begin
               cmd.emit   = EMIT_STATUS;
               cmd.status = STAT_FULL;
               cmd.last   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_RES_BAD: begin
            if (stat.out_free) begin
               cmd.emit   = EMIT_STATUS;
               cmd.status = STAT_BADPOS;
               cmd.last   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== src/ole_dpath.sv =====
`timescale 1ns / 1ps
// ole_dpath: request registers, entry count, entry ram, search hold and output register
// depends on ole_pkg and ole_ram; steered by ole_ctrl through dp_cmd_type

module ole_dpath import ole_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  dp_cmd_type      cmd,
   output dp_stat_type     stat
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > TOTAL_W) ? CW : TOTAL_W;

   op_type              op_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [AGE_W-1:0]    age_ff;
   logic [NAME_W-1:0]   name_ff;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic [CW-1:0]       idx_ff;
   logic [CW-1:0]       idx_in;
   logic [NMATCH_W-1:0] nmatch_ff;
   logic [NMATCH_W-1:0] nmatch_in;
   logic                pend_valid_ff;
   logic                pend_valid_in;
   logic [REC_W-1:0]    pend_rec_ff;
   logic [CW-1:0]       pend_idx_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_payload_type     rsp_ff;
   rsp_payload_type     rsp_in;

   logic [XW-1:0]       count_x;
   logic [XW-1:0]       pos_x;
   logic [XW-1:0]       idx_x;
   logic [XW-1:0]       ins_pos_x;
   logic [XW-1:0]       pend_idx_x;
   logic [CW-1:0]       idx_m1;
   logic [CW-1:0]       idx_p1;
   logic [IW-1:0]       rd_addr;
   logic [REC_W-1:0]    wr_data;
   logic [REC_W-1:0]    rd_data;
   logic [AGE_W-1:0]    rd_age;
   logic [NAME_W-1:0]   rd_name;

   assign count_x    = XW'(count_ff);
   assign pos_x      = XW'(pos_ff);
   assign idx_x      = XW'(idx_ff);
   assign pend_idx_x = XW'(pend_idx_ff);
   assign idx_m1     = idx_ff - CW'(1);
   assign idx_p1     = idx_ff + CW'(1);
   assign rd_age     = rd_data[REC_W-1 -: AGE_W];
   assign rd_name    = rd_data[NAME_W-1:0];

   // target slot of the insert in progress
   always_comb begin
      case (op_ff)
         OP_TAIL: ins_pos_x = count_x;
         OP_HEAD: ins_pos_x = '0;
         default: ins_pos_x = pos_x;
      endcase
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_IDX_M1: rd_addr = idx_m1[IW-1:0];
         RD_IDX_P1: rd_addr = idx_p1[IW-1:0];
         default:   rd_addr = idx_ff[IW-1:0];
      endcase
   end

   assign wr_data = (cmd.wr_sel == WR_NEW) ? {age_ff, name_ff} : rd_data;

   ole_ram #(
      .WIDTH (REC_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (idx_ff[IW-1:0]),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      case (cmd.idx_op)
         IDX_LOAD_COUNT: idx_in = count_ff;
         IDX_LOAD_POS:   idx_in = CW'(pos_x);
         IDX_CLEAR:      idx_in = '0;
         IDX_INC:        idx_in = idx_p1;
         IDX_DEC:        idx_in = idx_m1;
         default:        idx_in = idx_ff;
      endcase
   end

   always_comb begin
      case (cmd.cnt_op)
         CNT_INC:   count_in = count_ff + CW'(1);
         CNT_DEC:   count_in = count_ff - CW'(1);
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   always_comb begin
      nmatch_in     = nmatch_ff;
      pend_valid_in = pend_valid_ff;
      if (cmd.srch_init) begin
         nmatch_in     = '0;
         pend_valid_in = 1'b0;
      end else if (cmd.srch_take) begin
         nmatch_in     = nmatch_ff + NMATCH_W'(1);
         pend_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_in              = rsp_ff;
      rsp_in.entry_total  = count_x[TOTAL_W-1:0];
      rsp_in.last         = cmd.last;
      case (cmd.emit)
         EMIT_STATUS: begin
            rsp_in.status       = cmd.status;
            rsp_in.out_age      = '0;
            rsp_in.out_name     = '0;
            rsp_in.out_position = '0;
         end
         EMIT_READ: begin
            rsp_in.status       = STAT_OK;
            rsp_in.out_age      = rd_age;
            rsp_in.out_name     = rd_name;
            rsp_in.out_position = idx_x[POS_W-1:0];
         end
         EMIT_PEND: begin
            rsp_in.status       = STAT_OK;
            rsp_in.out_age      = pend_rec_ff[REC_W-1 -: AGE_W];
            rsp_in.out_name     = pend_rec_ff[NAME_W-1:0];
            rsp_in.out_position = pend_idx_x[POS_W-1:0];
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit != EMIT_NONE) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         idx_ff        <= '0;
         nmatch_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         nmatch_ff     <= nmatch_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= op_type'(req_payload.opcode);
         pos_ff  <= req_payload.position;
         age_ff  <= req_payload.age;
         name_ff <= req_payload.name_tag;
      end
      if (cmd.srch_take) begin
         pend_rec_ff <= rd_data;
         pend_idx_ff <= idx_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign stat.op         = op_ff;
   assign stat.full       = (count_ff == CW'(CAPACITY));
   assign stat.ins_bad    = (ins_pos_x > count_x);
   assign stat.pos_bad    = (pos_x >= count_x);
   assign stat.ins_here   = (idx_x == ins_pos_x);
   assign stat.rm_end     = (idx_p1 == count_ff);
   assign stat.scan_end   = (idx_ff == count_ff) || (nmatch_ff == NMATCH_W'(MAX_RESULTS));
   assign stat.match      = (rd_age == age_ff);
   assign stat.pend_valid = pend_valid_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== src/ordered_list_engine.sv =====
`timescale 1ns / 1ps
// channel  | direction | handshake          | carries
// req_bus  | in        | valid/ready        | opcode, position, age, name_tag
// rsp_bus  | out       | valid/ready        | status, out_age, out_name, out_position,
//          |           |                    | entry_total, last
//
// sequencing: one request at a time. insert shifts each entry at or above the target
// slot up by one, remove shifts each entry above the position down by one, and search
// scans the stored entries in order. each moved entry takes one registered read and
// one write of the entry ram.
// reset: synchronous, clears the entry count; entries hold no value until written.
// stalls: a busy response register holds the sequencer at its next response;
// new requests are taken only when the previous one is finished.
// depends on ole_pkg, ole_if, ole_ram, ole_ctrl and ole_dpath

module ordered_list_engine import ole_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input logic       clock,
   input logic       reset,
   ole_req_if.sink   req_bus,
   ole_rsp_if.source rsp_bus
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   ole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   ole_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_bus.payload),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_payload (rsp_bus.payload),
      .cmd         (dp_cmd),
      .stat        (dp_stat)
   );

endmodule
